[design/regx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regx_pkg
// Shared types, constants and decode helpers for the regex postfix converter.
// ----------------------------------------------------------------------------
package regx_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int MAX_ALTS_DEF    = 32;

    localparam int CHAR_W  = 8;
    localparam int STAT_W  = 2;
    localparam int ATOM_W  = 2;
    localparam int ALT_W   = 6;
    localparam int ENTRY_W = ATOM_W + ALT_W;

    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;  // '|'
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [STAT_W-1:0] ST_BYTE = 2'd0;
    localparam logic [STAT_W-1:0] ST_OK   = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJ  = 2'd2;

    typedef enum logic [2:0] {
        CL_OPEN, CL_CLOSE, CL_BAR, CL_QUANT, CL_LIT, CL_END
    } t_cls;

    typedef enum logic [2:0] {
        EM_DOT, EM_BAR, EM_CHAR, EM_OK, EM_REJ
    } t_emit;

    typedef enum logic [3:0] {
        OP_NONE, OP_SET_ERR, OP_CLEAR, OP_PUSH, OP_ALT_INC, OP_ALT_DEC,
        OP_ATOM_SET1, OP_ATOM_ZERO, OP_ATOM_INC, OP_POP, OP_RESTORE
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DOT, S_PUSH, S_BARS, S_POP, S_RESTORE, S_CHAR, S_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  emit;
        t_emit sel;
        logic  last;
        t_op   op;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic err;
        logic atom0;
        logic atom2;
        logic alt0;
        logic alt1;
        logic alt_full;
        logic ptr0;
        logic ptr_full;
        logic out_free;
    } t_stat;

    function automatic t_cls classify(input logic [CHAR_W-1:0] ch, input logic eop);
        t_cls c;
        if (eop) begin
            c = CL_END;
        end else begin
            unique case (ch) inside
                CH_OPEN:                    c = CL_OPEN;
                CH_CLOSE:                   c = CL_CLOSE;
                CH_BAR:                     c = CL_BAR;
                CH_STAR, CH_PLUS, CH_QMARK: c = CL_QUANT;
                default:                    c = CL_LIT;
            endcase
        end
        return c;
    endfunction

endpackage

[design/regx_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regx_ctrl
// Sequencer: decodes each pattern byte and steps the datapath through the
// words it must emit and the stack operations it must do.
// ----------------------------------------------------------------------------
module regx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  regx_pkg::t_stat i_stat,
    output regx_pkg::t_cmd  o_cmd
);
    import regx_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.sel  = EM_CHAR;
        o_cmd.last = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                // no word is taken while reset is applied
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_stat.cls)
                    CL_END: begin
                        if (i_stat.err || !i_stat.ptr0) n_state = S_FINISH;
                        else if (i_stat.atom2)          n_state = S_DOT;
                        else                            n_state = S_BARS;
                    end
                    CL_OPEN: begin
                        if (i_stat.err) begin
                            n_state = S_IDLE;
                        end else if (i_stat.ptr_full) begin
                            o_cmd.op = OP_SET_ERR;
                        end else if (i_stat.atom2) begin
                            n_state = S_DOT;
                        end else begin
                            o_cmd.op = OP_PUSH;
                        end
                    end
                    CL_BAR: begin
                        if (i_stat.err) begin
                            n_state = S_IDLE;
                        end else if (i_stat.atom0 || i_stat.alt_full) begin
                            o_cmd.op = OP_SET_ERR;
                        end else if (i_stat.atom2) begin
                            n_state = S_DOT;
                        end else begin
                            o_cmd.op = OP_ALT_INC;
                        end
                    end
                    CL_CLOSE: begin
                        if (i_stat.err) begin
                            n_state = S_IDLE;
                        end else if (i_stat.atom0 || i_stat.ptr0) begin
                            o_cmd.op = OP_SET_ERR;
                        end else if (i_stat.atom2) begin
                            n_state = S_DOT;
                        end else begin
                            o_cmd.op = OP_ATOM_ZERO;
                            n_state  = S_BARS;
                        end
                    end
                    CL_QUANT: begin
                        if (i_stat.err)        n_state  = S_IDLE;
                        else if (i_stat.atom0) o_cmd.op = OP_SET_ERR;
                        else                   n_state  = S_CHAR;
                    end
                    CL_LIT: begin
                        if (i_stat.err)        n_state = S_IDLE;
                        else if (i_stat.atom2) n_state = S_DOT;
                        else                   n_state = S_CHAR;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DOT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_DOT;
                    unique case (i_stat.cls)
                        CL_OPEN: begin
                            o_cmd.last = 1'b1;
                            o_cmd.op   = OP_ATOM_SET1;
                            n_state    = S_PUSH;
                        end
                        CL_BAR: begin
                            o_cmd.last = 1'b1;
                            o_cmd.op   = OP_ALT_INC;
                            n_state    = S_IDLE;
                        end
                        CL_CLOSE: begin
                            // no bars pending: the dot closes out this byte
                            o_cmd.last = i_stat.alt0;
                            o_cmd.op   = OP_ATOM_ZERO;
                            n_state    = S_BARS;
                        end
                        CL_END: begin
                            o_cmd.op = OP_ATOM_ZERO;
                            n_state  = S_BARS;
                        end
                        default: begin
                            o_cmd.op = OP_ATOM_SET1;
                            n_state  = S_CHAR;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH;
                n_state  = S_IDLE;
            end
            S_BARS: begin
                if (i_stat.alt0) begin
                    n_state = (i_stat.cls == CL_END) ? S_FINISH : S_POP;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_BAR;
                    o_cmd.last = (i_stat.cls == CL_CLOSE) && i_stat.alt1;
                    o_cmd.op   = OP_ALT_DEC;
                end
            end
            S_POP: begin
                o_cmd.op = OP_POP;
                n_state  = S_RESTORE;
            end
            S_RESTORE: begin
                o_cmd.op = OP_RESTORE;
                n_state  = S_IDLE;
            end
            S_CHAR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_CHAR;
                    o_cmd.last = 1'b1;
                    o_cmd.op   = (i_stat.cls == CL_LIT) ? OP_ATOM_INC : OP_NONE;
                    n_state    = S_IDLE;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = (i_stat.err || !i_stat.ptr0) ? EM_REJ : EM_OK;
                    o_cmd.last = 1'b1;
                    o_cmd.op   = OP_CLEAR;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[design/regx_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regx_dp
// Datapath: input latch, atom/alternation counters, group stack memory and
// the output word register.
// ----------------------------------------------------------------------------
module regx_dp #(
    parameter int STACK_DEPTH = regx_pkg::STACK_DEPTH_DEF,
    parameter int MAX_ALTS    = regx_pkg::MAX_ALTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [regx_pkg::CHAR_W-1:0] i_pat_char,
    input  logic                        i_end_of_pattern,
    input  regx_pkg::t_cmd              i_cmd,
    output regx_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [regx_pkg::CHAR_W-1:0] o_out_char,
    output logic [regx_pkg::STAT_W-1:0] o_status,
    output logic                        o_last
);
    import regx_pkg::*;

    localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [CHAR_W-1:0]  r_char;
    logic               r_eop;
    logic [ATOM_W-1:0]  r_atom, n_atom;
    logic [ALT_W-1:0]   r_alt, n_alt;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_err, n_err;
    logic [ENTRY_W-1:0] r_stack [STACK_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [STAT_W-1:0]  r_out_stat;
    logic               r_out_last;
    logic [PTR_W-1:0]   w_pop_ptr;
    logic [ATOM_W-1:0]  w_rd_atom;

    assign w_pop_ptr = r_ptr - PTR_W'(1);
    assign w_rd_atom = r_rd_data[ENTRY_W-1 -: ATOM_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_pat_char;
            r_eop  <= i_end_of_pattern;
        end
    end

    // group stack: one write for '(' and one registered read for ')'
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PUSH) begin
            r_stack[r_ptr[ADDR_W-1:0]] <= {r_atom, r_alt};
        end
        if (i_cmd.op == OP_POP) begin
            r_rd_data <= r_stack[w_pop_ptr[ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_atom = r_atom;
        n_alt  = r_alt;
        n_ptr  = r_ptr;
        n_err  = r_err;
        case (i_cmd.op)
            OP_SET_ERR: n_err = 1'b1;
            OP_CLEAR: begin
                n_atom = '0;
                n_alt  = '0;
                n_ptr  = '0;
                n_err  = 1'b0;
            end
            OP_PUSH: begin
                n_ptr  = r_ptr + PTR_W'(1);
                n_atom = '0;
                n_alt  = '0;
            end
            OP_ALT_INC: begin
                n_atom = '0;
                n_alt  = r_alt + ALT_W'(1);
            end
            OP_ALT_DEC:   n_alt  = r_alt - ALT_W'(1);
            OP_ATOM_SET1: n_atom = ATOM_W'(1);
            OP_ATOM_ZERO: n_atom = '0;
            OP_ATOM_INC:  n_atom = r_atom + ATOM_W'(1);
            OP_POP:       n_ptr  = w_pop_ptr;
            OP_RESTORE: begin
                // the group itself counts as one more atom, capped at two
                n_atom = (w_rd_atom != '0) ? ATOM_W'(2) : ATOM_W'(1);
                n_alt  = r_rd_data[ALT_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom <= '0;
            r_alt  <= '0;
            r_ptr  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_atom <= n_atom;
            r_alt  <= n_alt;
            r_ptr  <= n_ptr;
            r_err  <= n_err;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.last;
            case (i_cmd.sel)
                EM_DOT: begin
                    r_out_char <= CH_DOT;
                    r_out_stat <= ST_BYTE;
                end
                EM_BAR: begin
                    r_out_char <= CH_BAR;
                    r_out_stat <= ST_BYTE;
                end
                EM_OK: begin
                    r_out_char <= CH_NUL;
                    r_out_stat <= ST_OK;
                end
                EM_REJ: begin
                    r_out_char <= CH_NUL;
                    r_out_stat <= ST_REJ;
                end
                default: begin
                    r_out_char <= r_char;
                    r_out_stat <= ST_BYTE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_status    = r_out_stat;
    assign o_last      = r_out_last;

    assign o_stat.cls      = classify(r_char, r_eop);
    assign o_stat.err      = r_err;
    assign o_stat.atom0    = (r_atom == '0);
    assign o_stat.atom2    = (r_atom == ATOM_W'(2));
    assign o_stat.alt0     = (r_alt == '0);
    assign o_stat.alt1     = (r_alt == ALT_W'(1));
    assign o_stat.alt_full = (r_alt == ALT_W'(MAX_ALTS));
    assign o_stat.ptr0     = (r_ptr == '0);
    assign o_stat.ptr_full = (r_ptr == PTR_W'(STACK_DEPTH));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("word emitted over an untaken word");
    a_atom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_atom != ATOM_W'(3))
        else $error("atom count out of range");
    a_alt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alt <= ALT_W'(MAX_ALTS))
        else $error("alternation count above bound");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(STACK_DEPTH))
        else $error("stack pointer above depth");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_CLEAR) |=> (r_ptr == '0 && !r_err && r_atom == '0 && r_alt == '0))
        else $error("state not cleared at end of pattern");
`endif

endmodule

[design/regex_infix_to_postfix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_infix_to_postfix
// Converts a regular expression, one byte per word, to postfix with explicit
// concatenation dots.
// ----------------------------------------------------------------------------
// Input stream: one pattern byte per word in tdata; tlast marks end of
// pattern (tdata is then ignored). Output stream: postfix byte in tdata,
// tuser gives the kind (0 byte, 1 pattern ok, 2 pattern rejected), tlast is
// set on the final word caused by an input word.
// Each input word is accepted, then decoded, then the output words that
// it causes are emitted; ')' and an accepted end of pattern also pass a
// state that sees the bar count reach zero, ')' then the stack pop and
// the registered read, and '(' after two atoms the push. End of pattern
// and ')' emit one '|' per pending '|'. The rate is set by the single
// sequencer and the one stack port. A new input word is taken while the
// last output word still waits. When the output side stalls the
// sequencer holds in place; nothing
// is lost. Reset clears the counters, stack pointer, error flag and output
// valid and holds tready low; the stack contents are not cleared, only
// entries below the pointer are read.
// Errors are sticky and reported once, as a single rejected word at the end.
// ----------------------------------------------------------------------------
module regex_infix_to_postfix #(
    parameter int STACK_DEPTH = regx_pkg::STACK_DEPTH_DEF,
    parameter int MAX_ALTS    = regx_pkg::MAX_ALTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] pat_char
    input  logic       s_axis_tlast,   // end_of_pattern
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast    // last
);
    import regx_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    regx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    regx_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_ALTS    (MAX_ALTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pat_char       (s_axis_tdata),
        .i_end_of_pattern (s_axis_tlast),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_out_char       (m_axis_tdata),
        .o_status         (m_axis_tuser),
        .o_last           (m_axis_tlast)
    );

endmodule
